@@ hdl/acsc_pkg.sv @@
// ----------------------------------------------------------------------------
// acsc_pkg: alarm clock setting controller shared definitions
// mode codes, field widths, payload structs and the flash pattern table
// ----------------------------------------------------------------------------
`default_nettype none

package acsc_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned HOURS_W = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned IDLE_W  = 16;
  localparam int unsigned DIGIT_W = 2;
  localparam int unsigned POINT_W = 4;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_UNCONF  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SHOW    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADJ_MIN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADJ_HR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALM_MIN = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ALM_HR  = 3'd5;

  localparam logic [MIN_W-1:0]   MAX_MINUTES      = 6'd59;
  localparam logic [HOURS_W-1:0] MAX_HOURS        = 5'd23;
  localparam logic [IDLE_W-1:0]  IDLE_LIMIT_RESET = 16'd30000;

  typedef struct packed {
    logic               key_accept;
    logic               key_cancel;
    logic               key_set_time;
    logic               key_set_alarm;
    logic               key_up;
    logic               key_down;
    logic               clock_valid;
    logic               alarm_ringing;
    logic [HOURS_W-1:0] now_hours;
    logic [MIN_W-1:0]   now_minutes;
  } tick_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] flash_first;
    logic [DIGIT_W-1:0] flash_last;
    logic               flash_on;
    logic [POINT_W-1:0] point_flash_mask;
  } flash_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode_now;
    logic [HOURS_W-1:0] adj_hours;
    logic [MIN_W-1:0]   adj_minutes;
    logic               write_time;
    logic               write_alarm;
    logic               snooze;
    logic               finish_alarm;
    flash_t             flash;
  } result_t;

  function automatic flash_t flash_of(input logic [MODE_W-1:0] mode);
    flash_t f;
    case (mode)
      MODE_UNCONF:  f = '{2'd0, 2'd3, 1'b1, 4'h2};
      MODE_ADJ_MIN: f = '{2'd2, 2'd3, 1'b1, 4'h0};
      MODE_ADJ_HR:  f = '{2'd0, 2'd1, 1'b1, 4'h0};
      MODE_ALM_MIN: f = '{2'd2, 2'd3, 1'b1, 4'hF};
      MODE_ALM_HR:  f = '{2'd0, 2'd1, 1'b1, 4'hF};
      default:      f = '{2'd0, 2'd0, 1'b0, 4'h0};
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

@@ hdl/acsc_if.sv @@
// ----------------------------------------------------------------------------
// acsc_if: channel interfaces of the alarm clock setting controller
// tick request channel, result channel and idle limit write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface acsc_tick_if;
  logic       valid;
  logic       ready;
  logic       key_accept;
  logic       key_cancel;
  logic       key_set_time;
  logic       key_set_alarm;
  logic       key_up;
  logic       key_down;
  logic       clock_valid;
  logic       alarm_ringing;
  logic [4:0] now_hours;
  logic [5:0] now_minutes;

  modport source (
    output valid, key_accept, key_cancel, key_set_time, key_set_alarm, key_up,
           key_down, clock_valid, alarm_ringing, now_hours, now_minutes,
    input  ready
  );
  modport sink (
    input  valid, key_accept, key_cancel, key_set_time, key_set_alarm, key_up,
           key_down, clock_valid, alarm_ringing, now_hours, now_minutes,
    output ready
  );
endinterface

interface acsc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode_now;
  logic [4:0] adj_hours;
  logic [5:0] adj_minutes;
  logic       write_time;
  logic       write_alarm;
  logic       snooze;
  logic       finish_alarm;
  logic [1:0] flash_first;
  logic [1:0] flash_last;
  logic       flash_on;
  logic [3:0] point_flash_mask;

  modport source (
    output valid, mode_now, adj_hours, adj_minutes, write_time, write_alarm,
           snooze, finish_alarm, flash_first, flash_last, flash_on,
           point_flash_mask,
    input  ready
  );
  modport sink (
    input  valid, mode_now, adj_hours, adj_minutes, write_time, write_alarm,
           snooze, finish_alarm, flash_first, flash_last, flash_on,
           point_flash_mask,
    output ready
  );
endinterface

interface acsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hdl/acsc_in_stage.sv @@
// ----------------------------------------------------------------------------
// acsc_in_stage: tick input register
// holds one tick request until the step logic takes it
// ----------------------------------------------------------------------------
`default_nettype none

module acsc_in_stage
  import acsc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  acsc_tick_if.sink  in_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output tick_t      tick_o
);

  logic  valid_q, valid_d;
  tick_t tick_q;
  logic  load;

  // refill when empty or when the held tick leaves this cycle
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tick_q <= '{in_i.key_accept, in_i.key_cancel, in_i.key_set_time,
                  in_i.key_set_alarm, in_i.key_up, in_i.key_down,
                  in_i.clock_valid, in_i.alarm_ringing, in_i.now_hours,
                  in_i.now_minutes};
    end
  end

  assign valid_o = valid_q;
  assign tick_o  = tick_q;

endmodule

`default_nettype wire

@@ hdl/acsc_step.sv @@
// ----------------------------------------------------------------------------
// acsc_step: key handling and controller state
// applies one tick to mode, working time, alarm copy and idle counter
// ----------------------------------------------------------------------------
`default_nettype none

module acsc_step
  import acsc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire tick_t             tick_i,
  input  wire logic [IDLE_W-1:0] idle_limit_i,
  output result_t                result_o
);

  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [HOURS_W-1:0] work_hours_q, work_hours_d;
  logic [MIN_W-1:0]   work_minutes_q, work_minutes_d;
  logic [HOURS_W-1:0] alarm_hours_q, alarm_hours_d;
  logic [MIN_W-1:0]   alarm_minutes_q, alarm_minutes_d;
  logic [IDLE_W-1:0]  idle_q, idle_d;

  always_comb begin
    logic               clk_ok;
    logic               ringing;
    logic               any_key;
    logic               wt, wa, snz, fin;
    logic [MODE_W-1:0]  mode;
    logic [HOURS_W-1:0] wh;
    logic [MIN_W-1:0]   wm;
    logic [IDLE_W-1:0]  idle_inc;

    clk_ok          = tick_i.clock_valid;
    ringing         = tick_i.alarm_ringing;
    wt              = 1'b0;
    wa              = 1'b0;
    snz             = 1'b0;
    fin             = 1'b0;
    mode            = mode_q;
    wh              = work_hours_q;
    wm              = work_minutes_q;
    alarm_hours_d   = alarm_hours_q;
    alarm_minutes_d = alarm_minutes_q;
    any_key = tick_i.key_accept || tick_i.key_cancel || tick_i.key_set_time ||
              tick_i.key_set_alarm || tick_i.key_up || tick_i.key_down;

    if (tick_i.key_accept) begin
      if (ringing) begin
        snz     = 1'b1;
        ringing = 1'b0;
      end
      case (mode)
        MODE_ADJ_MIN: mode = MODE_ADJ_HR;
        MODE_ADJ_HR: begin
          wt     = 1'b1;
          clk_ok = 1'b1;
          mode   = MODE_SHOW;
        end
        MODE_ALM_MIN: mode = MODE_ALM_HR;
        MODE_ALM_HR: begin
          wa              = 1'b1;
          alarm_hours_d   = wh;
          alarm_minutes_d = wm;
          mode            = clk_ok ? MODE_SHOW : MODE_UNCONF;
        end
        default: ;
      endcase
    end
    if (tick_i.key_cancel) begin
      if (ringing) begin
        fin = 1'b1;
      end
      mode = clk_ok ? MODE_SHOW : MODE_UNCONF;
    end
    if (tick_i.key_set_time) begin
      mode = MODE_ADJ_MIN;
      wh   = tick_i.now_hours;
      wm   = tick_i.now_minutes;
    end
    if (tick_i.key_set_alarm) begin
      mode = MODE_ALM_MIN;
      wh   = alarm_hours_d;
      wm   = alarm_minutes_d;
    end
    if (tick_i.key_up) begin
      if (mode == MODE_ADJ_MIN || mode == MODE_ALM_MIN) begin
        wm = (wm >= MAX_MINUTES) ? '0 : wm + 1'b1;
      end else if (mode == MODE_ADJ_HR || mode == MODE_ALM_HR) begin
        wh = (wh >= MAX_HOURS) ? '0 : wh + 1'b1;
      end
    end
    if (tick_i.key_down) begin
      if (mode == MODE_ADJ_MIN || mode == MODE_ALM_MIN) begin
        wm = (wm == '0) ? MAX_MINUTES : wm - 1'b1;
      end else if (mode == MODE_ADJ_HR || mode == MODE_ALM_HR) begin
        wh = (wh == '0) ? MAX_HOURS : wh - 1'b1;
      end
    end

    // idle timeout: any key restarts the count, the add wraps at 16 bits
    idle_inc = any_key ? IDLE_W'(1) : idle_q + 1'b1;
    idle_d   = idle_inc;
    if (idle_inc >= idle_limit_i) begin
      idle_d = '0;
      if (mode >= MODE_ADJ_MIN && mode <= MODE_ALM_HR) begin
        mode = clk_ok ? MODE_SHOW : MODE_UNCONF;
      end
    end

    mode_d         = mode;
    work_hours_d   = wh;
    work_minutes_d = wm;

    result_o = '{mode, wh, wm, wt, wa, snz, fin, flash_of(mode)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_UNCONF;
      work_hours_q    <= '0;
      work_minutes_q  <= '0;
      alarm_hours_q   <= '0;
      alarm_minutes_q <= '0;
      idle_q          <= '0;
    end else if (fire_i) begin
      mode_q          <= mode_d;
      work_hours_q    <= work_hours_d;
      work_minutes_q  <= work_minutes_d;
      alarm_hours_q   <= alarm_hours_d;
      alarm_minutes_q <= alarm_minutes_d;
      idle_q          <= idle_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/acsc_out_stage.sv @@
// ----------------------------------------------------------------------------
// acsc_out_stage: result register
// holds one result until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module acsc_out_stage
  import acsc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire result_t  result_i,
  output logic          free_o,
  acsc_result_if.source out_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.mode_now         = res_q.mode_now;
  assign out_o.adj_hours        = res_q.adj_hours;
  assign out_o.adj_minutes      = res_q.adj_minutes;
  assign out_o.write_time       = res_q.write_time;
  assign out_o.write_alarm      = res_q.write_alarm;
  assign out_o.snooze           = res_q.snooze;
  assign out_o.finish_alarm     = res_q.finish_alarm;
  assign out_o.flash_first      = res_q.flash.flash_first;
  assign out_o.flash_last       = res_q.flash.flash_last;
  assign out_o.flash_on         = res_q.flash.flash_on;
  assign out_o.point_flash_mask = res_q.flash.point_flash_mask;

endmodule

`default_nettype wire

@@ hdl/alarm_clock_setting_controller_unit.sv @@
// ----------------------------------------------------------------------------
// alarm_clock_setting_controller_unit: alarm clock setting controller
// key-driven mode control for setting the clock time and the alarm time
// ----------------------------------------------------------------------------
// Each tick request carries six key flags plus the clock's validity, ringing
// flag and current time, and produces exactly one result: the mode after the
// tick, the working hour and minute, one-tick strobes for time write, alarm
// write, snooze and finish, and the display flash pattern of the mode. A tick
// goes through an input register, one pass of key logic against the state
// registers, and a result register, so the block takes one tick per clock
// while results are drained; a result is offered once its tick has passed
// both registers. A full, undrained result register stalls the input after
// one more tick. The user must write the idle limit (configuration channel,
// reset 30000) only while no tick is in flight; the block does not enforce it.
`default_nettype none

module alarm_clock_setting_controller_unit
  import acsc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  acsc_tick_if.sink     in_i,
  acsc_cfg_if.sink      cfg_i,
  acsc_result_if.source out_o
);

  logic              in_valid;
  tick_t             tick;
  logic              out_free;
  logic              fire;
  result_t           result;
  logic [IDLE_W-1:0] idle_limit_q;

  // idle limit register, always ready for a write
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= IDLE_LIMIT_RESET;
    end else if (cfg_i.valid) begin
      idle_limit_q <= cfg_i.data;
    end
  end

  // a held tick is processed when the result register can take its result
  assign fire = in_valid && out_free;

  acsc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (fire),
    .valid_o (in_valid),
    .tick_o  (tick)
  );

  // key handling plus mode, working time, alarm copy and idle state
  acsc_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .tick_i       (tick),
    .idle_limit_i (idle_limit_q),
    .result_o     (result)
  );

  acsc_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

@@ hdl/acsc_checker.sv @@
// ----------------------------------------------------------------------------
// acsc_checker: port-level checks of the alarm clock setting controller
// watches the result channel and is bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module acsc_checker
  import acsc_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [MODE_W-1:0]  mode_now_i,
  input wire logic [HOURS_W-1:0] adj_hours_i,
  input wire logic               snooze_i,
  input wire logic               finish_alarm_i,
  input wire logic               flash_on_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mode_now_i) &&
      $stable(adj_hours_i))
    else $error("stalled result changed");

  // snooze silences the alarm, so cancel in the same tick cannot finish it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(snooze_i && finish_alarm_i))
    else $error("snooze and finish in one result");

  // digits flash in every mode except showing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (flash_on_i == (mode_now_i != MODE_SHOW)))
    else $error("flash enable does not match mode");

  // only six modes exist
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (mode_now_i <= MODE_ALM_HR))
    else $error("mode code out of range");

endmodule

bind alarm_clock_setting_controller_unit acsc_checker u_acsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .mode_now_i     (out_o.mode_now),
  .adj_hours_i    (out_o.adj_hours),
  .snooze_i       (out_o.snooze),
  .finish_alarm_i (out_o.finish_alarm),
  .flash_on_i     (out_o.flash_on)
);

`default_nettype wire
